### hw/rtl/assert_macros.svh
// assertion macros shared by the date string parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)

`endif

`endif

### hw/rtl/pdsp_pkg.sv
// types, constants and tables of the date string parser
`default_nettype none

package pdsp_pkg;

   // field widths
   localparam int CharWidth    = 8;
   localparam int UtcWidth     = 39;
   localparam int ZoneMinWidth = 13;
   localparam int FieldWidth   = 14;
   localparam int CountWidth   = 3;
   localparam int YearWidth    = 14;
   localparam int MonthWidth   = 4;
   localparam int DayWidth     = 5;
   localparam int HourWidth    = 5;
   localparam int MinWidth     = 6;
   localparam int SecWidth     = 6;
   localparam int DoyWidth     = 9;

   // shared multiply-add unit
   localparam int MacAWidth = 36;
   localparam int MacBWidth = 12;
   localparam int AccWidth  = 40;

   // character codes
   localparam logic [CharWidth-1:0] CharD     = 8'h44;
   localparam logic [CharWidth-1:0] CharColon = 8'h3A;
   localparam logic [CharWidth-1:0] CharPlus  = 8'h2B;
   localparam logic [CharWidth-1:0] CharMinus = 8'h2D;
   localparam logic [CharWidth-1:0] CharZ     = 8'h5A;
   localparam logic [CharWidth-1:0] CharQuote = 8'h27;
   localparam logic [CharWidth-1:0] CharZero  = 8'h30;
   localparam logic [CharWidth-1:0] CharNine  = 8'h39;

   // field limits
   localparam logic [FieldWidth-1:0] YearMax    = 14'd9999;
   localparam logic [FieldWidth-1:0] MonthMax   = 14'd12;
   localparam logic [FieldWidth-1:0] DayMax     = 14'd31;
   localparam logic [FieldWidth-1:0] HourMax    = 14'd23;
   localparam logic [FieldWidth-1:0] MinSecMax  = 14'd59;
   localparam logic [CountWidth-1:0] YearDigits = 3'd4;
   localparam logic [CountWidth-1:0] PairDigits = 3'd2;

   // calendar arithmetic: year shifted by one 400-year era keeps it positive
   localparam int YearBias       = 400;
   localparam int DaysPerYear    = 365;
   localparam int HoursPerDay    = 24;
   localparam int SixtyUnits     = 60;
   // ceil(2^16 / 25), also ceil(2^18 / 100): quarter-year count to centuries
   localparam int RecipCentury   = 2622;
   localparam int CenturyShift   = 16;
   localparam int QuadCentShift  = 18;
   // days from the biased march-based origin to 1970-01-01, plus one for day 1
   localparam int DayEpochShift  = 865566;

   // zone marker
   typedef enum logic [1:0] {
      ZoneNone,
      ZonePlus,
      ZoneMinus,
      ZoneUtc
   } pdsp_zone_type;

   // parsed fields handed from the scanner to the converter
   typedef struct packed {
      logic                  ok;
      logic [YearWidth-1:0]  year;
      logic [MonthWidth-1:0] month;
      logic [DayWidth-1:0]   day;
      logic [HourWidth-1:0]  hour;
      logic [MinWidth-1:0]   minute;
      logic [SecWidth-1:0]   second;
      pdsp_zone_type         zsign;
      logic [MinWidth-1:0]   zhour;
      logic [MinWidth-1:0]   zminute;
   } pdsp_snap_type;

   // days before the month in a year that starts in march
   function automatic logic [DoyWidth-1:0] month_offset(input logic [MonthWidth-1:0] month);
      logic [DoyWidth-1:0] offs;
      case (month)
         4'd3:    offs = 9'd0;
         4'd4:    offs = 9'd31;
         4'd5:    offs = 9'd61;
         4'd6:    offs = 9'd92;
         4'd7:    offs = 9'd122;
         4'd8:    offs = 9'd153;
         4'd9:    offs = 9'd184;
         4'd10:   offs = 9'd214;
         4'd11:   offs = 9'd245;
         4'd12:   offs = 9'd275;
         4'd1:    offs = 9'd306;
         4'd2:    offs = 9'd337;
         default: offs = 9'd0;
      endcase
      return offs;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/pdsp_if.sv
// valid/ready channels for characters in and parsed dates out
`default_nettype none

interface pdsp_req_if import pdsp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] char_code;
   logic                 last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface pdsp_rsp_if import pdsp_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic                           date_valid;
   logic signed [UtcWidth-1:0]     utc_seconds;
   logic                           has_zone;
   logic signed [ZoneMinWidth-1:0] zone_minutes;

   modport source (output valid, output date_valid, output utc_seconds,
                   output has_zone, output zone_minutes, input ready);
   modport sink   (input valid, input date_valid, input utc_seconds,
                   input has_zone, input zone_minutes, output ready);
endinterface

`default_nettype wire

### hw/rtl/pdf_date_string_parser.sv
// top level of the date string parser: scanner plus converter
//
//   channel  dir  fields                                                       accepted when
//   req_if   in   char_code[7:0], last_char                                    valid && ready
//   rsp_if   out  date_valid, utc_seconds[38:0], has_zone, zone_minutes[12:0]  valid && ready
//
// an ordinary character is handled in the scanner alone
// the final character passes the scanner, then takes six passes through
// the shared multiply-add unit, the last of which loads the result register
// req_if.ready is low during those six passes
// the last pass holds while the previous item still waits on rsp_if
// reset is synchronous and returns the scanner to the start of a string
`default_nettype none
`include "assert_macros.svh"

module pdf_date_string_parser import pdsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pdsp_req_if.sink    req_if,
   pdsp_rsp_if.source  rsp_if
);

   logic          take;
   logic          start;
   logic          conv_idle;
   pdsp_snap_type snap;

   // characters are taken whenever the converter is free
   assign req_if.ready = conv_idle;
   assign take         = req_if.valid && req_if.ready;

   pdsp_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .take_i  (take),
      .char_i  (req_if.char_code),
      .last_i  (req_if.last_char),
      .start_o (start),
      .snap_o  (snap)
   );

   pdsp_conv u_conv (
      .clock       (clock),
      .reset       (reset),
      .start_i     (start),
      .snap_i      (snap),
      .idle_o      (conv_idle),
      .res_valid_o (rsp_if.valid),
      .res_ready_i (rsp_if.ready),
      .res_ok_o    (rsp_if.date_valid),
      .res_utc_o   (rsp_if.utc_seconds),
      .res_zone_o  (rsp_if.has_zone),
      .res_zmin_o  (rsp_if.zone_minutes)
   );

   `ASSERT_NEVER(a_handshake_known, clock, reset, $isunknown({req_if.ready, rsp_if.valid}))

endmodule

`default_nettype wire

### hw/rtl/pdsp_mac.sv
// shared signed multiply-add unit: y = a * b + c
`default_nettype none

module pdsp_mac import pdsp_pkg::*; (
   input  logic signed [MacAWidth-1:0] a_i,
   input  logic        [MacBWidth-1:0] b_i,
   input  logic signed [AccWidth-1:0]  c_i,
   output logic signed [AccWidth-1:0]  y_o
);

   logic signed [MacAWidth+MacBWidth:0] prod;

   // multiplier constant is always positive
   assign prod = a_i * $signed({1'b0, b_i});
   assign y_o  = $signed(prod[AccWidth-1:0]) + c_i;

endmodule

`default_nettype wire

### hw/rtl/pdsp_scan.sv
// character scanner: prefix, fixed-width fields, range checks and zone
`default_nettype none
`include "assert_macros.svh"

module pdsp_scan import pdsp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take_i,
   input  logic [CharWidth-1:0] char_i,
   input  logic                 last_i,
   output logic                 start_o,
   output pdsp_snap_type        snap_o
);

   typedef enum logic [3:0] {
      PH_START,
      PH_COLON,
      PH_YEAR,
      PH_MONTH,
      PH_DAY,
      PH_HOUR,
      PH_MINUTE,
      PH_SECOND,
      PH_ZHOUR,
      PH_ZQUOTE,
      PH_ZMIN,
      PH_ZCLOSE,
      PH_DONE,
      PH_ZSTART
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [FieldWidth-1:0]  field_ff, field_in;
   logic [YearWidth-1:0]   year_ff, year_in;
   logic [MonthWidth-1:0]  month_ff, month_in;
   logic [DayWidth-1:0]    day_ff, day_in;
   logic [HourWidth-1:0]   hour_ff, hour_in;
   logic [MinWidth-1:0]    minute_ff, minute_in;
   logic [SecWidth-1:0]    second_ff, second_in;
   pdsp_zone_type          zsign_ff, zsign_in;
   logic [MinWidth-1:0]    zhour_ff, zhour_in;
   logic [MinWidth-1:0]    zminute_ff, zminute_in;
   logic                   err_ff, err_in;

   logic                   is_zone;
   logic                   is_digit;
   logic                   take_zone;
   logic                   do_digit;
   phase_type              dig_phase;
   logic [FieldWidth-1:0]  field_sum;
   logic [CountWidth-1:0]  count_inc;
   logic [CountWidth-1:0]  field_len;
   logic [FieldWidth-1:0]  field_lo;
   logic [FieldWidth-1:0]  field_hi;
   logic                   end_ok;

   // character classes
   assign is_zone   = (char_i == CharPlus) || (char_i == CharMinus) || (char_i == CharZ);
   assign is_digit  = (char_i >= CharZero) && (char_i <= CharNine);
   assign field_sum = (field_ff << 3) + (field_ff << 1) + {10'd0, char_i[3:0]};
   assign count_inc = count_ff + 3'd1;

   // width and limits of the field being read
   always_comb begin
      field_len = PairDigits;
      field_lo  = '0;
      field_hi  = MinSecMax;
      unique case (dig_phase)
         PH_YEAR: begin
            field_len = YearDigits;
            field_hi  = YearMax;
         end
         PH_MONTH: begin
            field_lo = 14'd1;
            field_hi = MonthMax;
         end
         PH_DAY: begin
            field_lo = 14'd1;
            field_hi = DayMax;
         end
         PH_HOUR: begin
            field_hi = HourMax;
         end
         default: begin
            field_hi = MinSecMax;
         end
      endcase
   end

   // next state for one character
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      field_in   = field_ff;
      year_in    = year_ff;
      month_in   = month_ff;
      day_in     = day_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      zsign_in   = zsign_ff;
      zhour_in   = zhour_ff;
      zminute_in = zminute_ff;
      err_in     = err_ff;
      take_zone  = 1'b0;
      do_digit   = 1'b0;
      dig_phase  = phase_ff;

      // dispatch on phase, nothing moves once an error is seen
      if (!err_ff) begin
         unique case (phase_ff)
            PH_START: begin
               if (char_i == CharD) begin
                  phase_in = PH_COLON;
               end else begin
                  phase_in  = PH_YEAR;
                  dig_phase = PH_YEAR;
                  do_digit  = 1'b1;
               end
            end
            PH_COLON: begin
               if (char_i == CharColon) phase_in = PH_YEAR;
               else err_in = 1'b1;
            end
            PH_YEAR, PH_ZHOUR, PH_ZMIN: begin
               do_digit = 1'b1;
            end
            PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND: begin
               if (count_ff == '0 && is_zone) take_zone = 1'b1;
               else do_digit = 1'b1;
            end
            PH_ZSTART: begin
               if (is_zone) take_zone = 1'b1;
               else err_in = 1'b1;
            end
            PH_ZQUOTE: begin
               if (char_i == CharQuote) phase_in = PH_ZMIN;
               else err_in = 1'b1;
            end
            PH_ZCLOSE: begin
               if (char_i == CharQuote) phase_in = PH_DONE;
               else err_in = 1'b1;
            end
            default: begin
               err_in = 1'b1;
            end
         endcase
      end

      // zone marker starts the zone fields
      if (take_zone) begin
         count_in = '0;
         field_in = '0;
         if (char_i == CharZ) begin
            zsign_in = ZoneUtc;
            phase_in = PH_DONE;
         end else begin
            zsign_in = (char_i == CharPlus) ? ZonePlus : ZoneMinus;
            phase_in = PH_ZHOUR;
         end
      end

      // digit accumulate, range check and store on the field's last digit
      if (do_digit) begin
         if (!is_digit) begin
            err_in = 1'b1;
         end else begin
            field_in = field_sum;
            count_in = count_inc;
            if (count_inc == field_len) begin
               field_in = '0;
               count_in = '0;
               if (field_sum < field_lo || field_sum > field_hi) begin
                  err_in = 1'b1;
               end else begin
                  unique case (dig_phase)
                     PH_YEAR: begin
                        year_in  = field_sum;
                        phase_in = PH_MONTH;
                     end
                     PH_MONTH: begin
                        month_in = field_sum[MonthWidth-1:0];
                        phase_in = PH_DAY;
                     end
                     PH_DAY: begin
                        day_in   = field_sum[DayWidth-1:0];
                        phase_in = PH_HOUR;
                     end
                     PH_HOUR: begin
                        hour_in  = field_sum[HourWidth-1:0];
                        phase_in = PH_MINUTE;
                     end
                     PH_MINUTE: begin
                        minute_in = field_sum[MinWidth-1:0];
                        phase_in  = PH_SECOND;
                     end
                     PH_SECOND: begin
                        second_in = field_sum[SecWidth-1:0];
                        phase_in  = PH_ZSTART;
                     end
                     PH_ZHOUR: begin
                        zhour_in = field_sum[MinWidth-1:0];
                        phase_in = PH_ZQUOTE;
                     end
                     PH_ZMIN: begin
                        zminute_in = field_sum[MinWidth-1:0];
                        phase_in   = PH_ZCLOSE;
                     end
                     default: begin
                        err_in = 1'b1;
                     end
                  endcase
               end
            end
         end
      end
   end

   // string may stop between fields after the year, after the zone hour, or after the zone
   always_comb begin
      unique case (phase_in)
         PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND: end_ok = (count_in == '0);
         PH_ZSTART, PH_ZQUOTE, PH_DONE:                   end_ok = 1'b1;
         default:                                         end_ok = 1'b0;
      endcase
   end

   // fields as they stand after the final character
   assign start_o         = take_i && last_i;
   assign snap_o.ok       = !err_in && end_ok;
   assign snap_o.year     = year_in;
   assign snap_o.month    = month_in;
   assign snap_o.day      = day_in;
   assign snap_o.hour     = hour_in;
   assign snap_o.minute   = minute_in;
   assign snap_o.second   = second_in;
   assign snap_o.zsign    = zsign_in;
   assign snap_o.zhour    = zhour_in;
   assign snap_o.zminute  = zminute_in;

   // scanner state, back to defaults after the final character
   always_ff @(posedge clock) begin
      if (reset || (take_i && last_i)) begin
         phase_ff   <= PH_START;
         count_ff   <= '0;
         field_ff   <= '0;
         year_ff    <= '0;
         month_ff   <= 4'd1;
         day_ff     <= 5'd1;
         hour_ff    <= '0;
         minute_ff  <= '0;
         second_ff  <= '0;
         zsign_ff   <= ZoneNone;
         zhour_ff   <= '0;
         zminute_ff <= '0;
         err_ff     <= 1'b0;
      end else if (take_i) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         field_ff   <= field_in;
         year_ff    <= year_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         second_ff  <= second_in;
         zsign_ff   <= zsign_in;
         zhour_ff   <= zhour_in;
         zminute_ff <= zminute_in;
         err_ff     <= err_in;
      end
   end

   `ASSERT_ALWAYS(a_clear_after_last, clock, reset, (take_i && last_i) |=> (phase_ff == PH_START && !err_ff && count_ff == '0))
   `ASSERT_ALWAYS(a_count_in_field, clock, reset, count_ff < YearDigits)

endmodule

`default_nettype wire

### hw/rtl/pdsp_conv.sv
// civil date to utc seconds, six passes through the shared multiply-add unit
`default_nettype none
`include "assert_macros.svh"

module pdsp_conv import pdsp_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start_i,
   input  pdsp_snap_type                  snap_i,
   output logic                           idle_o,
   output logic                           res_valid_o,
   input  logic                           res_ready_i,
   output logic                           res_ok_o,
   output logic signed [UtcWidth-1:0]     res_utc_o,
   output logic                           res_zone_o,
   output logic signed [ZoneMinWidth-1:0] res_zmin_o
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZONE,
      ST_QUOT,
      ST_DAYS,
      ST_HOUR,
      ST_MIN,
      ST_SEC
   } state_type;

   state_type                      state_ff;
   pdsp_snap_type                  snap_ff;
   logic signed [AccWidth-1:0]     acc_ff;
   logic signed [ZoneMinWidth-1:0] zmin_ff;
   logic                           res_valid_ff;
   logic                           res_ok_ff;
   logic signed [UtcWidth-1:0]     res_utc_ff;
   logic                           res_zone_ff;
   logic signed [ZoneMinWidth-1:0] res_zmin_ff;

   logic                           early_month;
   logic [YearWidth-1:0]           year_biased;
   logic [YearWidth-3:0]           year_quarter;
   logic [ZoneMinWidth-1:0]        zone_mag;
   logic signed [MacAWidth-1:0]    mac_a;
   logic [MacBWidth-1:0]           mac_b;
   logic signed [AccWidth-1:0]     mac_c;
   logic signed [AccWidth-1:0]     mac_y;
   logic                           res_load;

   // january and february count with the previous year
   assign early_month  = (snap_ff.month <= 4'd2);
   assign year_biased  = snap_ff.year + YearWidth'(YearBias) - {{(YearWidth-1){1'b0}}, early_month};
   assign year_quarter = year_biased[YearWidth-1:2];
   assign zone_mag     = {1'b0, acc_ff[ZoneMinWidth-2:0]};

   // last pass may load the result register once it is free
   assign res_load = (state_ff == ST_SEC) && (!res_valid_ff || res_ready_i);

   // operand select for the current pass
   always_comb begin
      mac_a = '0;
      mac_b = '0;
      mac_c = '0;
      unique case (state_ff)
         ST_ZONE: begin
            // zone offset magnitude in minutes
            mac_a = MacAWidth'(snap_ff.zhour);
            mac_b = MacBWidth'(SixtyUnits);
            mac_c = AccWidth'(snap_ff.zminute);
         end
         ST_QUOT: begin
            // reciprocal product gives year/100 and year/400
            mac_a = MacAWidth'(year_quarter);
            mac_b = MacBWidth'(RecipCentury);
         end
         ST_DAYS: begin
            mac_a = MacAWidth'(year_biased);
            mac_b = MacBWidth'(DaysPerYear);
            mac_c = AccWidth'(year_quarter)
                  - AccWidth'(acc_ff[22:CenturyShift])
                  + AccWidth'(acc_ff[22:QuadCentShift])
                  + AccWidth'(month_offset(snap_ff.month))
                  + AccWidth'(snap_ff.day)
                  - AccWidth'(DayEpochShift);
         end
         ST_HOUR: begin
            mac_a = acc_ff[MacAWidth-1:0];
            mac_b = MacBWidth'(HoursPerDay);
            mac_c = AccWidth'(snap_ff.hour);
         end
         ST_MIN: begin
            // local minutes minus zone offset
            mac_a = acc_ff[MacAWidth-1:0];
            mac_b = MacBWidth'(SixtyUnits);
            mac_c = AccWidth'(snap_ff.minute)
                  - {{(AccWidth-ZoneMinWidth){zmin_ff[ZoneMinWidth-1]}}, zmin_ff};
         end
         ST_SEC: begin
            mac_a = acc_ff[MacAWidth-1:0];
            mac_b = MacBWidth'(SixtyUnits);
            mac_c = AccWidth'(snap_ff.second);
         end
         default: begin
            mac_a = '0;
         end
      endcase
   end

   pdsp_mac u_mac (
      .a_i (mac_a),
      .b_i (mac_b),
      .c_i (mac_c),
      .y_o (mac_y)
   );

   // sequencer with accumulator and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start_i) begin
                  snap_ff  <= snap_i;
                  state_ff <= ST_ZONE;
               end
            end
            ST_ZONE: begin
               acc_ff   <= mac_y;
               state_ff <= ST_QUOT;
            end
            ST_QUOT: begin
               unique case (snap_ff.zsign)
                  ZonePlus:  zmin_ff <= $signed(zone_mag);
                  ZoneMinus: zmin_ff <= -$signed(zone_mag);
                  default:   zmin_ff <= '0;
               endcase
               acc_ff   <= mac_y;
               state_ff <= ST_DAYS;
            end
            ST_DAYS: begin
               acc_ff   <= mac_y;
               state_ff <= ST_HOUR;
            end
            ST_HOUR: begin
               acc_ff   <= mac_y;
               state_ff <= ST_MIN;
            end
            ST_MIN: begin
               acc_ff   <= mac_y;
               state_ff <= ST_SEC;
            end
            ST_SEC: begin
               // hold the last pass while the previous item still waits
               if (res_load) begin
                  res_ok_ff   <= snap_ff.ok;
                  res_utc_ff  <= snap_ff.ok ? mac_y[UtcWidth-1:0] : '0;
                  res_zone_ff <= snap_ff.ok && (snap_ff.zsign != ZoneNone);
                  res_zmin_ff <= snap_ff.ok ? zmin_ff : '0;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // result valid: set by the last pass, cleared when taken
         if (res_load) res_valid_ff <= 1'b1;
         else if (res_ready_i) res_valid_ff <= 1'b0;
      end
   end

   assign idle_o      = (state_ff == ST_IDLE);
   assign res_valid_o = res_valid_ff;
   assign res_ok_o    = res_ok_ff;
   assign res_utc_o   = res_utc_ff;
   assign res_zone_o  = res_zone_ff;
   assign res_zmin_o  = res_zmin_ff;

   `ASSERT_ALWAYS(a_start_when_idle, clock, reset, start_i |-> (state_ff == ST_IDLE))
   `ASSERT_ALWAYS(a_rsp_held, clock, reset, (res_valid_ff && !res_ready_i) |=> (res_valid_ff && $stable(res_utc_ff)))
   `ASSERT_ALWAYS(a_invalid_zeroed, clock, reset, (res_valid_ff && !res_ok_ff) |-> (res_utc_ff == '0 && !res_zone_ff && res_zmin_ff == '0))

endmodule

`default_nettype wire
